@@ rtl/kst_pkg.sv @@
package kst_pkg;

    // Field widths fixed by the interface.
    localparam int LEVEL_W    = 15;
    localparam int ID_W       = 8;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // Parameter defaults.
    localparam int TABLE_SIZE_DEF    = 64;
    localparam int FRACTION_BITS_DEF = 8;

    // Request operations.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    // Takeover modes.
    localparam logic [MODE_W-1:0] MODE_PICKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_JUMP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REL    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SCALED = 2'd3;

    // Takeover status codes.
    localparam logic [STATUS_W-1:0] ST_CAPTURED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BELOW    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABOVE    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 1'd1;

    localparam logic [LEVEL_W-1:0] TOL_RESET = 15'd256;

    // Q16 arithmetic for scaled catch-up.
    localparam int Q16_ONE  = 65536;
    localparam int Q16_HALF = 32768;
    localparam int Q16_CAP  = 52429;

    // Reciprocal of 127: floor(y / 127) == (y * RECIP_127) >> RECIP_SHIFT for y < 2**Y_W.
    localparam int RECIP_127   = 8454661;
    localparam int RECIP_SHIFT = 30;
    localparam int Y_W         = 23;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    typedef struct packed {
        logic               operation;
        logic [ID_W-1:0]    entry_id;
        logic [LEVEL_W-1:0] physical_value;
        logic [LEVEL_W-1:0] saved_value;
    } t_req;

    typedef struct packed {
        logic [LEVEL_W-1:0]  effective_value;
        logic [STATUS_W-1:0] status;
    } t_res;

endpackage

@@ rtl/knob_soft_takeover.sv @@
// An update goes through the load and done states into the output register; in scaled
// catch-up mode, while the entry is still approaching, it also passes MUL1 and MUL2
// (two passes through the shared multiplier). One request at a time; a reset request
// every cycle while idle, and a stalled result holds the next update.
// Reset is synchronous and active low: it clears the sequencer, the output valid flag and
// all table valid bits at once, with no clearing pass, and loads the configuration defaults.
module knob_soft_takeover #(
    parameter int TABLE_SIZE    = kst_pkg::TABLE_SIZE_DEF,
    parameter int FRACTION_BITS = kst_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  kst_pkg::t_req                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output kst_pkg::t_res                   o_out,
    input  logic                            i_cfg_we,
    input  logic [kst_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kst_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Internal level width: 7 integer bits plus the fraction. Every level the
    // table holds is saturated to 127.0, so it always fits in LVLW bits.
    localparam int LVLW    = 7 + FRACTION_BITS;
    localparam int CW      = (LVLW > kst_pkg::LEVEL_W) ? LVLW : kst_pkg::LEVEL_W;
    localparam int SW      = CW + 2;
    localparam int IDXW    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int LVL_MAX = 127 << FRACTION_BITS;
    localparam logic [CW-1:0] LVL_MAX_C = CW'(LVL_MAX);
    localparam logic signed [SW-1:0] LVL_MAX_S = SW'(LVL_MAX);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Zero extension of a level into the signed working width.
    function automatic logic signed [SW-1:0] sx(input logic [LVLW-1:0] v);
        return $signed(SW'(v));
    endfunction

    function automatic logic signed [SW-1:0] sabs(input logic signed [SW-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // Clamp a signed working value to the level range 0..127.0.
    function automatic logic [LVLW-1:0] sat(input logic signed [SW-1:0] v);
        logic [LVLW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > LVL_MAX_S) begin
            res = LVLW'(LVL_MAX);
        end else begin
            res = LVLW'(v);
        end
        return res;
    endfunction

    // Saturate an incoming 15-bit level to 127.0.
    function automatic logic [LVLW-1:0] sat_in(input logic [kst_pkg::LEVEL_W-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        return (w > LVL_MAX_C) ? LVLW'(LVL_MAX) : LVLW'(w);
    endfunction

    // Configuration registers.
    logic [kst_pkg::MODE_W-1:0]  r_mode;
    logic [kst_pkg::LEVEL_W-1:0] r_tol;

    // Per-entry table. The valid bits live in flip-flops; the level and
    // status words sit in memories and only matter once an entry is valid.
    logic [LVLW-1:0]              m_stored [TABLE_SIZE];
    logic [LVLW-1:0]              m_last   [TABLE_SIZE];
    logic [kst_pkg::STATUS_W-1:0] m_stat   [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]        r_valid;

    // Sequencer and request registers.
    logic [2:0]                   r_state, n_state;
    logic                         r_inr;
    logic [IDXW-1:0]              r_idx;
    logic [LVLW-1:0]              r_phys;
    logic [LVLW-1:0]              r_saved;
    logic [LVLW-1:0]              r_rd_stored;
    logic [LVLW-1:0]              r_rd_last;
    logic [kst_pkg::STATUS_W-1:0] r_rd_stat;

    // Entry after the first-touch merge, and the derived working values.
    logic [LVLW-1:0]              r_stored;
    logic [kst_pkg::STATUS_W-1:0] r_stat;
    logic signed [SW-1:0]         r_delta;
    logic [LVLW-1:0]              r_dist;
    logic [kst_pkg::PROD_W-1:0]   r_prod;

    // Output register.
    logic                         r_out_valid;
    kst_pkg::t_res                r_out;

    logic                         in_acc;
    logic                         in_range;
    logic [IDXW-1:0]              in_idx;
    logic                         out_free;
    logic signed [SW-1:0]         tol_s;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign in_range    = {1'b0, i_in.entry_id} < (kst_pkg::ID_W + 1)'(TABLE_SIZE);
    assign in_idx      = i_in.entry_id[IDXW-1:0];
    assign out_free    = !r_out_valid || i_out_ready;
    assign tol_s       = $signed(SW'(r_tol));
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Load step: an entry that has never been touched (or was reset) takes
    // the saved level as its stored level and the knob as its last level,
    // and its status follows from where the knob sits against the saved level.
    // ------------------------------------------------------------------
    logic                         ld_valid;
    logic [LVLW-1:0]              ld_stored;
    logic [LVLW-1:0]              ld_last;
    logic [kst_pkg::STATUS_W-1:0] ld_stat;
    logic [kst_pkg::STATUS_W-1:0] init_stat;
    logic signed [SW-1:0]         ld_delta;
    logic signed [SW-1:0]         ld_dist;
    logic                         ld_scaled;

    always_comb begin
        ld_valid = r_inr && r_valid[r_idx];
        if (sabs(sx(r_phys) - sx(r_saved)) <= tol_s) begin
            init_stat = kst_pkg::ST_CAPTURED;
        end else if (r_phys < r_saved) begin
            init_stat = kst_pkg::ST_BELOW;
        end else begin
            init_stat = kst_pkg::ST_ABOVE;
        end
        ld_stored = ld_valid ? r_rd_stored : r_saved;
        ld_last   = ld_valid ? r_rd_last   : r_phys;
        ld_stat   = ld_valid ? r_rd_stat   : init_stat;
        ld_delta  = sx(r_phys) - sx(ld_last);
        ld_dist   = sabs(sx(ld_stored) - sx(r_phys));
        ld_scaled = r_inr && (r_mode == kst_pkg::MODE_SCALED)
                    && (ld_stat != kst_pkg::ST_CAPTURED);
    end

    // ------------------------------------------------------------------
    // Shared multiplier. First pass: distance scaled to Q16 times the
    // reciprocal of 127, which gives the catch-up fraction. Second pass:
    // the magnitude of the knob change times (1 - fraction).
    // ------------------------------------------------------------------
    logic [kst_pkg::Y_W-1:0]    mul_y;
    logic [kst_pkg::PROD_W-1:0] frac_raw;
    logic [16:0]                frac;
    logic [16:0]                scale;
    logic [LVLW-1:0]            abs_delta;
    logic [kst_pkg::MUL_W-1:0]  mul_a;
    logic [kst_pkg::MUL_W-1:0]  mul_b;

    always_comb begin
        mul_y     = kst_pkg::Y_W'(r_dist) << (16 - FRACTION_BITS);
        frac_raw  = r_prod >> kst_pkg::RECIP_SHIFT;
        frac      = (frac_raw > kst_pkg::PROD_W'(kst_pkg::Q16_CAP))
                    ? 17'(kst_pkg::Q16_CAP) : frac_raw[16:0];
        scale     = 17'(kst_pkg::Q16_ONE) - frac;
        abs_delta = LVLW'(sabs(r_delta));
        if (r_state == S_MUL1) begin
            mul_a = kst_pkg::MUL_W'(mul_y);
            mul_b = kst_pkg::MUL_W'(kst_pkg::RECIP_127);
        end else begin
            mul_a = kst_pkg::MUL_W'(abs_delta);
            mul_b = kst_pkg::MUL_W'(scale);
        end
    end

    // ------------------------------------------------------------------
    // Finish step: pick the result and the entry write-back per mode.
    // ------------------------------------------------------------------
    logic [kst_pkg::PROD_W-1:0]   mag_full;
    logic signed [SW-1:0]         mag;
    logic [LVLW-1:0]              rel_new;
    logic [LVLW-1:0]              sc_new;
    logic [kst_pkg::STATUS_W-1:0] sc_stat;
    logic                         pk_hit;
    logic [LVLW-1:0]              dn_lvl;
    logic [kst_pkg::STATUS_W-1:0] dn_stat;
    logic [LVLW-1:0]              wr_stored;
    logic [CW-1:0]                dn_lvl_c;

    always_comb begin
        mag_full = r_prod + kst_pkg::PROD_W'(kst_pkg::Q16_HALF);
        mag      = $signed(SW'(mag_full >> 16));
        rel_new  = sat(sx(r_stored) + r_delta);
        sc_new   = sat(sx(r_stored) + ((r_delta < 0) ? -mag : mag));
        sc_stat  = (sabs(sx(r_phys) - sx(sc_new)) <= tol_s) ? kst_pkg::ST_CAPTURED : r_stat;
        pk_hit   = ((r_stat == kst_pkg::ST_BELOW) && (sx(r_phys) >= sx(r_saved) - tol_s))
                || ((r_stat == kst_pkg::ST_ABOVE) && (sx(r_phys) <= sx(r_saved) + tol_s))
                || (sabs(sx(r_phys) - sx(r_saved)) <= tol_s);

        // Out of range, jump, or captured/caught outside REL: the knob drives the parameter.
        dn_lvl    = r_phys;
        dn_stat   = kst_pkg::ST_CAPTURED;
        wr_stored = r_phys;
        if (r_inr) begin
            if (r_mode == kst_pkg::MODE_REL) begin
                dn_lvl    = rel_new;
                wr_stored = rel_new;
            end else if ((r_mode == kst_pkg::MODE_SCALED)
                         && (r_stat != kst_pkg::ST_CAPTURED)) begin
                dn_lvl    = sc_new;
                dn_stat   = sc_stat;
                wr_stored = sc_new;
            end else if ((r_mode != kst_pkg::MODE_JUMP)
                         && (r_stat != kst_pkg::ST_CAPTURED) && !pk_hit) begin
                // Pickup still waiting: hold the stored level.
                dn_lvl    = r_stored;
                dn_stat   = r_stat;
                wr_stored = r_stored;
            end
        end
        dn_lvl_c = CW'(dn_lvl);
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.operation == kst_pkg::OP_UPDATE)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = ld_scaled ? S_MUL1 : S_DONE;
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_mode      <= kst_pkg::MODE_PICKUP;
            r_tol       <= kst_pkg::TOL_RESET;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == kst_pkg::CFG_MODE) begin
                    r_mode <= i_cfg_data[kst_pkg::MODE_W-1:0];
                end else if (i_cfg_idx == kst_pkg::CFG_TOL) begin
                    r_tol <= i_cfg_data;
                end
            end

            // A reset request only needs to drop the valid bit: the next
            // update of that entry reloads every field from the request.
            if (in_acc && (i_in.operation == kst_pkg::OP_RESET) && in_range) begin
                r_valid[in_idx] <= 1'b0;
            end

            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
                if (r_inr) begin
                    r_valid[r_idx] <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and table read.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_inr   <= in_range;
            r_idx   <= in_idx;
            r_phys  <= sat_in(i_in.physical_value);
            r_saved <= sat_in(i_in.saved_value);
            if (in_range) begin
                r_rd_stored <= m_stored[in_idx];
                r_rd_last   <= m_last[in_idx];
                r_rd_stat   <= m_stat[in_idx];
            end
        end
    end

    // Working registers and the shared multiplier product.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_stored <= ld_stored;
            r_stat   <= ld_stat;
            r_delta  <= ld_delta;
            r_dist   <= LVLW'(ld_dist);
        end
        if ((r_state == S_MUL1) || (r_state == S_MUL2)) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // Result register and table write-back. Every in-range update leaves
    // last_physical at the knob level.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out.effective_value <= dn_lvl_c[kst_pkg::LEVEL_W-1:0];
            r_out.status          <= dn_stat;
            if (r_inr) begin
                m_stored[r_idx] <= wr_stored;
                m_last[r_idx]   <= r_phys;
                m_stat[r_idx]   <= dn_stat;
            end
        end
    end

endmodule

@@ rtl/kst_checker.sv @@
module kst_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  kst_pkg::t_req                   i_in,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  kst_pkg::t_res                   o_out
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // An update request keeps the block busy for at least the next cycle.
    a_busy_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.operation == kst_pkg::OP_UPDATE)) |=> !o_in_ready)
        else $error("ready did not drop after an update request");

    // A reset request with nothing pending never produces a result.
    a_reset_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.operation == kst_pkg::OP_RESET) && !o_out_valid) |=> !o_out_valid)
        else $error("reset request produced a result");

    // Reported status is always one of the three takeover codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.status == kst_pkg::ST_CAPTURED)
                      || (o_out.status == kst_pkg::ST_BELOW)
                      || (o_out.status == kst_pkg::ST_ABOVE)))
        else $error("illegal status code on result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind knob_soft_takeover kst_checker u_kst_checker (.*);
